// ===== rtl/positional_insert_delete_list_assert.svh =====
// ----------------------------------------------------------------------------
// positional insert/delete list assertion macros
// shared property forms for the list checker, clocked on clk, reset on arst_n
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

// consequent checked in the same cycle
`define PIDL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pidl assertion failed");

// consequent checked in the following cycle
`define PIDL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pidl assertion failed");

`endif

// ===== rtl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg
// shared types, codes and constants of the positional insert/delete list
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int FILL_OUT_W   = 8;
	localparam int CAPACITY_DEF = 128;
	localparam int TREE_FAN     = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_APPEND = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// broadcast to every cell in the execute cycle
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

	// number of registered levels of the fan-in tree over n leaves
	function automatic int tree_levels(input int n);
		int lv;
		int span;
		lv   = 0;
		span = 1;
		while (span < n) begin
			span = span * TREE_FAN;
			lv   = lv + 1;
		end
		if (lv == 0) begin
			lv = 1;
		end
		return lv;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell
// one list slot: takes its left or right neighbor on a shift, or the new word
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell import pidl_pkg::*; #(
	parameter int IDX_W = 7
) (
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic [IDX_W-1:0]  sel_idx,
	input  wire logic [IDX_W-1:0]  cell_index,
	input  wire logic [DATA_W-1:0] left_data,
	input  wire logic [DATA_W-1:0] right_data,
	output logic      [DATA_W-1:0] data,
	output logic      [DATA_W-1:0] hit_data
);

	logic [DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (cell_index == sel_idx) begin
				entry_q <= ctl.value;
			end else if (cell_index > sel_idx) begin
				entry_q <= left_data;
			end
		end else if (ctl.del) begin
			if (cell_index >= sel_idx) begin
				entry_q <= right_data;
			end
		end
	end

	assign data     = entry_q;
	// only the addressed slot puts its word on the reduction tree
	assign hit_data = (cell_index == sel_idx) ? entry_q : '0;

endmodule

`default_nettype wire

// ===== rtl/pidl_or_tree.sv =====
// ----------------------------------------------------------------------------
// pidl_or_tree
// registered or-reduction of the cells' selected words, fan-in 8 per level
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_or_tree import pidl_pkg::*; #(
	parameter int N = CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic [DATA_W-1:0] leaf [N],
	output logic      [DATA_W-1:0] root
);

	localparam int LEVELS = tree_levels(N);

	logic [DATA_W-1:0] lvl_q [LEVELS][N];

	always_ff @(posedge clk) begin
		int                idx;
		logic [DATA_W-1:0] acc;
		for (int l = 0; l < LEVELS; l++) begin
			for (int j = 0; j < N; j++) begin
				acc = '0;
				for (int k = 0; k < TREE_FAN; k++) begin
					idx = j * TREE_FAN + k;
					if (idx < N) begin
						if (l == 0) begin
							acc = acc | leaf[idx];
						end else begin
							acc = acc | lvl_q[l-1][idx];
						end
					end
				end
				lvl_q[l][j] <= acc;
			end
		end
	end

	assign root = lvl_q[LEVELS-1][0];

endmodule

`default_nettype wire

// ===== rtl/positional_insert_delete_list.sv =====
// a request passes the execute state, then the reduce state, which waits until every level
//   of the registered or-tree that gathers the addressed cell's word for read and delete
//   has filled, then the done state; a new request is taken only once back in idle
// insert, delete and append shift every cell of the chain together in the execute state
// reset: arst_n clears the fill count, the sequencer and out_valid; the cell
//   words are not reset and are only read below the fill count
`default_nettype none

module positional_insert_delete_list import pidl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            operation,
	input  wire logic [POS_W-1:0]      position,
	input  wire logic [DATA_W-1:0]     value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [1:0]            status,
	output logic      [DATA_W-1:0]     data_out,
	output logic      [FILL_OUT_W-1:0] fill_after
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int LEVELS = tree_levels(CAPACITY);
	localparam int LVL_W  = $clog2(LEVELS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REDUCE,
		S_DONE
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [POS_W-1:0]        pos_q;
	logic [DATA_W-1:0]       val_q;
	logic [CNT_W-1:0]        fill_q;
	logic [LVL_W-1:0]        cnt_q;
	status_t                 res_status_q;
	logic [FILL_OUT_W-1:0]   res_fill_q;
	logic                    want_q;
	logic [DATA_W-1:0]       res_data_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [DATA_W-1:0]       out_data_q;
	logic [FILL_OUT_W-1:0]   out_fill_q;

	logic [CMP_W-1:0]        fill_e;
	logic [CMP_W-1:0]        pos_e;
	logic [CMP_W-1:0]        idx_e;
	logic [CMP_W-1:0]        fill_nxt_e;
	logic                    is_full;
	logic                    is_empty;
	logic                    pos_ins_ok;
	logic                    pos_ok;
	status_t                 dec_status;
	logic                    dec_ins;
	logic                    dec_del;
	logic                    dec_want;
	logic [IDX_W-1:0]        sel_idx;
	cell_ctl_t               cell_ctl;
	logic                    out_free;

	logic [DATA_W-1:0]       cell_data  [CAPACITY];
	logic [DATA_W-1:0]       left_data  [CAPACITY];
	logic [DATA_W-1:0]       right_data [CAPACITY];
	logic [DATA_W-1:0]       hit_data   [CAPACITY];
	logic [DATA_W-1:0]       tree_root;

	// request decode against the current fill count
	always_comb begin
		fill_e     = CMP_W'(fill_q);
		pos_e      = CMP_W'(pos_q);
		is_full    = (fill_e == CMP_W'(CAPACITY));
		is_empty   = (fill_e == '0);
		pos_ins_ok = (pos_e != '0) && (pos_e <= fill_e + CMP_W'(1));
		pos_ok     = (pos_e != '0) && (pos_e <= fill_e);
		dec_status = ST_OK;
		dec_ins    = 1'b0;
		dec_del    = 1'b0;
		dec_want   = 1'b0;
		idx_e      = pos_e - CMP_W'(1);
		fill_nxt_e = fill_e;
		case (op_q)
			OP_INSERT: begin
				if (is_full) begin
					dec_status = ST_FULL;
				end else if (!pos_ins_ok) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_ins    = 1'b1;
					fill_nxt_e = fill_e + CMP_W'(1);
				end
			end
			OP_DELETE: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else if (!pos_ok) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_del    = 1'b1;
					dec_want   = 1'b1;
					fill_nxt_e = fill_e - CMP_W'(1);
				end
			end
			OP_APPEND: begin
				// append is an insert at the slot just past the last word
				idx_e = fill_e;
				if (is_full) begin
					dec_status = ST_FULL;
				end else begin
					dec_ins    = 1'b1;
					fill_nxt_e = fill_e + CMP_W'(1);
				end
			end
			OP_READ: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else if (!pos_ok) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_want = 1'b1;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	assign sel_idx        = idx_e[IDX_W-1:0];
	assign cell_ctl.ins   = (state_q == S_EXEC) && dec_ins;
	assign cell_ctl.del   = (state_q == S_EXEC) && dec_del;
	assign cell_ctl.value = val_q;

	// cell chain, each slot wired to its neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(g);

		if (g == 0) begin : g_first
			assign left_data[g] = '0;
		end else begin : g_mid_l
			assign left_data[g] = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_data[g] = cell_data[g];
		end else begin : g_mid_r
			assign right_data[g] = cell_data[g+1];
		end

		pidl_cell #(
			.IDX_W (IDX_W)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.sel_idx    (sel_idx),
			.cell_index (CELL_IDX),
			.left_data  (left_data[g]),
			.right_data (right_data[g]),
			.data       (cell_data[g]),
			.hit_data   (hit_data[g])
		);
	end

	pidl_or_tree #(
		.N (CAPACITY)
	) u_or_tree (
		.clk  (clk),
		.leaf (hit_data),
		.root (tree_root)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the done state loads the next result itself
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(operation);
						pos_q   <= position;
						val_q   <= value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					fill_q       <= fill_nxt_e[CNT_W-1:0];
					res_status_q <= dec_status;
					res_fill_q   <= fill_nxt_e[FILL_OUT_W-1:0];
					want_q       <= dec_want;
					cnt_q        <= LVL_W'(LEVELS - 1);
					state_q      <= S_REDUCE;
				end
				S_REDUCE: begin
					// tree root holds the pre-shift word once every level has filled
					if (cnt_q == '0) begin
						res_data_q <= want_q ? tree_root : '0;
						state_q    <= S_DONE;
					end else begin
						cnt_q <= cnt_q - LVL_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_data_q   <= res_data_q;
						out_fill_q   <= res_fill_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign data_out   = out_data_q;
	assign fill_after = out_fill_q;

endmodule

`default_nettype wire

// ===== rtl/pidl_checker.sv =====
// ----------------------------------------------------------------------------
// pidl_checker
// port-level checks of the positional insert/delete list, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_insert_delete_list_assert.svh"

module pidl_checker import pidl_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic [1:0]            operation,
	input wire logic [POS_W-1:0]      position,
	input wire logic [DATA_W-1:0]     value,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [1:0]            status,
	input wire logic [DATA_W-1:0]     data_out,
	input wire logic [FILL_OUT_W-1:0] fill_after
);

	// a request in flight blocks the next one
	`PIDL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// an error result never carries a word
	`PIDL_ASSERT_SAME(a_err_no_data, out_valid && (status != ST_OK), data_out == '0)

	`PIDL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	`PIDL_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(status) && $stable(data_out) && $stable(fill_after))

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (.*);

`default_nettype wire

// ===== dv/positional_insert_delete_list_tb.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list_tb
// checks the positional list against a queue-based mirror of its contents;
// directed corner requests, then random fill / drain / mixed phases, with
// random idling on both handshakes and one long hold-off on the result side
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list_tb;
	import pidl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_CAP     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 850;
	localparam int HOLD_AFTER   = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [1:0]            status;
		logic [DATA_W-1:0]     data;
		logic [FILL_OUT_W-1:0] fill;
	} list_result_t;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	// mirror of the stored list and the results it predicts
	class list_mirror;
		logic [DATA_W-1:0] words[$];
		list_result_t      expected_results[$];
		int                checked;

		function new();
			checked = 0;
		endfunction

		function int fill();
			return words.size();
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void note_request(op_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
			list_result_t r;
			int n;
			int p;
			n        = words.size();
			p        = int'(pos);
			r.status = ST_OK;
			r.data   = '0;
			case (op)
				OP_INSERT: begin
					if (n >= LIST_CAP) begin
						r.status = ST_FULL;
					end else if (p < 1 || p > n + 1) begin
						r.status = ST_BADPOS;
					end else if (p == n + 1) begin
						words.push_back(val);
					end else begin
						words.insert(p - 1, val);
					end
				end
				OP_DELETE: begin
					if (n == 0) begin
						r.status = ST_EMPTY;
					end else if (p < 1 || p > n) begin
						r.status = ST_BADPOS;
					end else begin
						r.data = words[p - 1];
						words.delete(p - 1);
					end
				end
				OP_APPEND: begin
					if (n >= LIST_CAP) begin
						r.status = ST_FULL;
					end else begin
						words.push_back(val);
					end
				end
				default: begin
					if (n == 0) begin
						r.status = ST_EMPTY;
					end else if (p < 1 || p > n) begin
						r.status = ST_BADPOS;
					end else begin
						r.data = words[p - 1];
					end
				end
			endcase
			r.fill = FILL_OUT_W'(words.size());
			expected_results.push_back(r);
		endfunction

		// empty string when the result matches the oldest prediction
		function string check_result(logic [1:0] st, logic [DATA_W-1:0] d,
				logic [FILL_OUT_W-1:0] f);
			list_result_t e;
			string msg;
			if (expected_results.size() == 0) begin
				return $sformatf("unexpected result status=%0d data=%h fill=%0d", st, d, f);
			end
			e   = expected_results.pop_front();
			msg = "";
			if (st !== e.status) begin
				msg = {msg, $sformatf(" status got %0d exp %0d", st, e.status)};
			end
			if (d !== e.data) begin
				msg = {msg, $sformatf(" data_out got %h exp %h", d, e.data)};
			end
			if (f !== e.fill) begin
				msg = {msg, $sformatf(" fill_after got %0d exp %0d", f, e.fill)};
			end
			if (msg != "") begin
				msg = {$sformatf("result %0d:", checked), msg};
			end
			checked++;
			return msg;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            operation = '0;
	logic [POS_W-1:0]      position = '0;
	logic [DATA_W-1:0]     value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [DATA_W-1:0]     data_out;
	logic [FILL_OUT_W-1:0] fill_after;

	logic                  steady = 1'b0;
	int                    mismatch_count = 0;
	list_mirror            sb = new();

	positional_insert_delete_list #(.CAPACITY(LIST_CAP)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data_out   (data_out),
		.fill_after (fill_after)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// offer one request and hold it until accepted
	task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		while (!steady && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		position  <= pos;
		value     <= val;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_request(op, pos, val);
	endtask

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(int lo, int hi);
		return POS_W'($urandom_range(hi, lo));
	endfunction

	// result side: check, then choose the next stall
	initial begin
		int    hold;
		int    results_seen;
		string msg;
		hold         = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				msg = sb.check_result(status, data_out, fill_after);
				if (msg != "") begin
					report_mismatch(msg);
				end
				results_seen++;
				if (results_seen == HOLD_AFTER) begin
					hold = HOLD_CYCLES;
				end
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < 29);
			end
		end
	end

	initial begin
		#2_400_000;
		$display("positional_insert_delete_list_tb: FAIL");
		$finish;
	end

	initial begin
		phase_t           phase;
		int               n;
		int               r;
		int               edge_hits;
		int               mixed_left;
		op_t              op;
		logic [POS_W-1:0] pos;
		string            msg;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: empty beats bad position
		send_request(OP_READ,   8'd1,   32'h1234_5678);
		send_request(OP_DELETE, 8'd1,   32'h0);
		send_request(OP_DELETE, 8'd0,   32'hffff_ffff);
		send_request(OP_READ,   8'd0,   32'h0);
		send_request(OP_INSERT, 8'd0,   32'h1111_1111);
		send_request(OP_INSERT, 8'd2,   32'h2222_2222);
		send_request(OP_INSERT, 8'd1,   32'h8000_0000);
		send_request(OP_APPEND, 8'd129, 32'h7fff_ffff);
		// insert one past the end appends
		send_request(OP_INSERT, 8'd3,   32'hffff_ffff);
		send_request(OP_INSERT, 8'd1,   32'h0000_0000);
		send_request(OP_INSERT, 8'd6,   32'h3333_3333);
		send_request(OP_READ,   8'd0,   32'h0);
		send_request(OP_READ,   8'd5,   32'h0);
		send_request(OP_READ,   8'd4,   32'h0);
		send_request(OP_READ,   8'd1,   32'h0);
		send_request(OP_READ,   8'd129, 32'h0);
		send_request(OP_DELETE, 8'd5,   32'h0);
		send_request(OP_DELETE, 8'd0,   32'h0);
		send_request(OP_DELETE, 8'd2,   32'h0);
		send_request(OP_DELETE, 8'd3,   32'h0);
		send_request(OP_INSERT, 8'd2,   32'h5555_aaaa);
		send_request(OP_READ,   8'd2,   32'h0);
		send_request(OP_DELETE, 8'd1,   32'h0);
		send_request(OP_DELETE, 8'd1,   32'h0);
		send_request(OP_DELETE, 8'd1,   32'h0);

		phase      = PH_FILL;
		edge_hits  = 0;
		mixed_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 400 && i < 520);
			n      = sb.fill();
			// walk full -> drain -> empty -> mixed -> fill
			case (phase)
				PH_FILL: begin
					if (n == LIST_CAP) begin
						edge_hits++;
					end
					if (edge_hits > 8) begin
						phase     = PH_DRAIN;
						edge_hits = 0;
					end
				end
				PH_DRAIN: begin
					if (n == 0) begin
						edge_hits++;
					end
					if (edge_hits > 4) begin
						phase      = PH_MIXED;
						edge_hits  = 0;
						mixed_left = 60;
					end
				end
				default: begin
					mixed_left--;
					if (mixed_left <= 0) begin
						phase = PH_FILL;
					end
				end
			endcase

			r = $urandom_range(99);
			if (r < 15) begin
				// noise: any operation, any position from 0 to 129
				op  = op_t'($urandom_range(3));
				pos = pick_pos(0, 129);
			end else begin
				r = $urandom_range(99);
				case (phase)
					PH_FILL: begin
						if (r < 45) begin
							op = OP_APPEND;
						end else if (r < 85) begin
							op = OP_INSERT;
						end else begin
							op = OP_READ;
						end
					end
					PH_DRAIN: begin
						if (r < 75) begin
							op = OP_DELETE;
						end else if (r < 90) begin
							op = OP_READ;
						end else begin
							op = OP_INSERT;
						end
					end
					default: begin
						op = op_t'(r % 4);
					end
				endcase
				if (op == OP_INSERT) begin
					pos = pick_pos(1, n + 1);
				end else if (op == OP_APPEND) begin
					pos = pick_pos(0, 129);
				end else begin
					pos = pick_pos(1, (n > 0) ? n : 1);
				end
			end
			send_request(op, pos, pick_word());
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			msg = $sformatf("%0d results never arrived", sb.pending());
			report_mismatch(msg);
		end
		if (mismatch_count == 0) begin
			$display("positional_insert_delete_list_tb: PASS");
		end else begin
			$display("positional_insert_delete_list_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
